@@ design/lrd_pkg.sv @@
// Package for the log record deframer: types, constants and the CRC-32 byte update.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none
package lrd_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int POS_W = 48;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TRAILER = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        V_GOOD  = 2'd0,
        V_MAGIC = 2'd1,
        V_TRUNC = 2'd2,
        V_CRC   = 2'd3
    } verdict_t;

    localparam logic [1:0] REG_RECORD_MAGIC = 2'd0;

    // One result beat as it leaves the parser.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [63:0] record_tag;
        logic        payload_first;
        logic        payload_last;
        logic [1:0]  verdict;
        logic [47:0] consumed_offset;
        logic [31:0] payload_length;
    } result_t;

    // One input beat after the front end has registered it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        segment_start;
        logic [47:0] first_offset;
        logic        segment_end;
    } item_t;

    // Reflected CRC-32 over one byte, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ design/lrd_if.sv @@
// Valid/ready stream interfaces for the deframer's input and result channels.
// Depends on lrd_pkg for the beat types.
`timescale 1ns / 1ps
`default_nettype none
interface lrd_in_if;
    import lrd_pkg::*;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        segment_start;
    logic [47:0] first_offset;
    logic        segment_end;
    modport source (output valid, data_byte, segment_start, first_offset, segment_end,
                    input ready);
    modport sink (input valid, data_byte, segment_start, first_offset, segment_end,
                  output ready);
endinterface

interface lrd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [63:0] record_tag;
    logic        payload_first;
    logic        payload_last;
    logic [1:0]  verdict;
    logic [47:0] consumed_offset;
    logic [31:0] payload_length;
    modport source (output valid, result_kind, payload_byte, record_tag, payload_first,
                    payload_last, verdict, consumed_offset, payload_length, input ready);
    modport sink (input valid, result_kind, payload_byte, record_tag, payload_first,
                  payload_last, verdict, consumed_offset, payload_length, output ready);
endinterface
`default_nettype wire

@@ design/log_record_deframer_crc.sv @@
// Top level of the log record deframer: APB register, input queue and parser.
// Depends on lrd_pkg, lrd_if, lrd_queue and lrd_parser.
//
//  channel | dir | handshake      | beat
//  in_ch   | in  | valid/ready    | data_byte, segment_start, first_offset, segment_end
//  out_ch  | out | valid/ready    | one payload byte or one record verdict
//  apb     | in  | psel/penable   | record_magic at address 0
//
// One byte a cycle unless out_ch stalls; the parser updates the CRC combinationally.
// A result appears in the cycle after its byte leaves the queue.
// A two-entry queue lets input keep flowing while results stall, until it fills.
// rst_n clears all control state asynchronously; the parser starts stopped.
`timescale 1ns / 1ps
`default_nettype none
module log_record_deframer_crc
    import lrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    lrd_in_if.sink           in_ch,
    lrd_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [31:0] magic_reg;
    logic        q_full, q_ne, q_pop;
    item_t       q_in, q_head;
    result_t     res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_RECORD_MAGIC) ? magic_reg : 32'd0;

    // Register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= '0;
        else if (psel && penable && pwrite && paddr == REG_RECORD_MAGIC)
            magic_reg <= pwdata;
    end

    assign in_ch.ready = !q_full;
    assign q_in = '{data_byte: in_ch.data_byte, segment_start: in_ch.segment_start,
                    first_offset: in_ch.first_offset, segment_end: in_ch.segment_end};

    lrd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(in_ch.valid && !q_full), .push_item(q_in),
        .full(q_full), .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    lrd_parser u_parser (
        .clk(clk), .rst_n(rst_n), .record_magic(magic_reg), .in_valid(q_ne),
        .in_item(q_head), .in_pop(q_pop), .out_valid(out_ch.valid),
        .out_ready(out_ch.ready), .out_res(res)
    );

    assign out_ch.result_kind     = res.result_kind;
    assign out_ch.payload_byte    = res.payload_byte;
    assign out_ch.record_tag      = res.record_tag;
    assign out_ch.payload_first   = res.payload_first;
    assign out_ch.payload_last    = res.payload_last;
    assign out_ch.verdict         = res.verdict;
    assign out_ch.consumed_offset = res.consumed_offset;
    assign out_ch.payload_length  = res.payload_length;
endmodule
`default_nettype wire

@@ design/lrd_queue.sv @@
// Two-entry queue of input beats between the front end and the parser.
// Depends on lrd_pkg for item_t.
`timescale 1ns / 1ps
`default_nettype none
module lrd_queue
    import lrd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head
);
    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overrun");
    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("queue underrun");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");
endmodule
`default_nettype wire

@@ design/lrd_parser.sv @@
// Record parser: header capture, CRC update, payload forwarding and verdicts.
// Depends on lrd_pkg; fed from lrd_queue, drives a one-entry output register.
`timescale 1ns / 1ps
`default_nettype none
module lrd_parser
    import lrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] record_magic,
    input  wire logic        in_valid,
    input  item_t            in_item,
    output logic             in_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output result_t          out_res
);
    phase_t               phase_reg, phase_next;
    logic [31:0]          cnt_reg, cnt_next;
    logic [31:0]          hword_reg, hword_next;
    logic [31:0]          psize_reg, psize_next;
    logic [63:0]          tag_reg, tag_next;
    logic [31:0]          crc_reg, crc_next;
    logic [31:0]          scrc_reg, scrc_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, gend_reg, gend_next;
    logic                 ovalid_reg;
    result_t              ores_reg;
    logic                 emit;
    result_t              res;

    // Step when output register is free or is draining this cycle.
    assign in_pop    = in_valid && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;

    // Next state and result of one byte.
    always_comb
    begin
        logic [OFFSET_BITS-1:0] pos_s, gend_s;
        logic [31:0] crc_s, idx, hw_s, ps_s, sc_s;
        logic [63:0] tag_s;
        phase_t      ph_s;
        logic [7:0]  b;
        logic [2:0]  vd;
        logic        ve;
        pos_s = pos_reg; gend_s = gend_reg; crc_s = crc_reg; idx = cnt_reg;
        hw_s = hword_reg; ps_s = psize_reg; sc_s = scrc_reg; tag_s = tag_reg;
        ph_s = phase_reg; b = in_item.data_byte; vd = 3'd0; ve = 1'b0;
        emit = 1'b0; res = '0;
        if (in_item.segment_start)
        begin
            pos_s = OFFSET_BITS'(in_item.first_offset);
            gend_s = pos_s; ph_s = PH_HEADER; idx = '0; hw_s = '0; ps_s = '0;
            tag_s = '0; crc_s = '1; sc_s = '0;
        end
        phase_next = ph_s; cnt_next = idx; hword_next = hw_s; psize_next = ps_s;
        tag_next = tag_s; crc_next = crc_s; scrc_next = sc_s; pos_next = pos_s;
        gend_next = gend_s;
        if (ph_s != PH_STOPPED)
        begin
            pos_next = pos_s + OFFSET_BITS'(1);
            unique case (ph_s)
                PH_HEADER:
                begin
                    crc_next = crc_byte(crc_s, b);
                    if (idx < 32'd4)
                        hword_next = hw_s | ({24'd0, b} << {idx[1:0], 3'b000});
                    else if (idx < 32'd8)
                        psize_next = ps_s | ({24'd0, b} << {idx[1:0], 3'b000});
                    else if (idx < 32'd16)
                        tag_next = tag_s | ({56'd0, b} << {idx[2:0], 3'b000});
                    if (idx < 32'd23)
                    begin
                        cnt_next = idx + 32'd1;
                        if (in_item.segment_end)
                        begin
                            ve = 1'b1; vd = {1'b0, V_TRUNC};
                        end
                    end
                    else if (hw_s != record_magic)
                    begin
                        ve = 1'b1; vd = {1'b0, V_MAGIC};
                    end
                    else
                    begin
                        cnt_next = '0;
                        phase_next = (ps_s == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
                        if (in_item.segment_end)
                        begin
                            ve = 1'b1; vd = {1'b0, V_TRUNC};
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next = crc_byte(crc_s, b);
                    if (in_item.segment_end)
                    begin
                        ve = 1'b1; vd = {1'b0, V_TRUNC};
                    end
                    else
                    begin
                        if (idx == ps_s - 32'd1)
                        begin
                            phase_next = PH_TRAILER; cnt_next = '0;
                        end
                        else
                            cnt_next = idx + 32'd1;
                        emit = 1'b1;
                        res.result_kind = 1'b0;
                        res.payload_byte = b;
                        res.payload_first = (idx == 32'd0);
                        res.payload_last = (idx == ps_s - 32'd1);
                    end
                end
                PH_TRAILER:
                begin
                    scrc_next = sc_s | ({24'd0, b} << {idx[1:0], 3'b000});
                    if (idx < 32'd3)
                    begin
                        cnt_next = idx + 32'd1;
                        if (in_item.segment_end)
                        begin
                            ve = 1'b1; vd = {1'b0, V_TRUNC};
                        end
                    end
                    else if (~crc_s != scrc_next)
                    begin
                        ve = 1'b1; vd = {1'b0, V_CRC};
                    end
                    else
                    begin
                        gend_next = pos_next;
                        ve = 1'b1; vd = {1'b0, V_GOOD};
                        if (!in_item.segment_end)
                        begin
                            phase_next = PH_HEADER; cnt_next = '0; hword_next = '0;
                            psize_next = '0; tag_next = '0; crc_next = '1; scrc_next = '0;
                        end
                        else
                            vd[2] = 1'b1;
                    end
                end
                default: ;
            endcase
            if (ve)
            begin
                emit = 1'b1;
                res.result_kind = 1'b1;
                res.verdict = vd[1:0];
                if (vd[1:0] != V_GOOD || vd[2])
                    phase_next = PH_STOPPED;
            end
            // Header fields include this byte; a good verdict reports them before the
            // next record clears them.
            res.record_tag = tag_next;
            res.payload_length = psize_next;
            if (ve && vd[1:0] == V_GOOD)
            begin
                res.record_tag = tag_s;
                res.payload_length = ps_s;
            end
            res.consumed_offset = POS_W'(gend_next);
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOPPED; cnt_reg <= '0; hword_reg <= '0; psize_reg <= '0;
            tag_reg <= '0; crc_reg <= '1; scrc_reg <= '0; pos_reg <= '0; gend_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (in_pop)
            begin
                phase_reg <= phase_next; cnt_reg <= cnt_next; hword_reg <= hword_next;
                psize_reg <= psize_next; tag_reg <= tag_next; crc_reg <= crc_next;
                scrc_reg <= scrc_next; pos_reg <= pos_next; gend_reg <= gend_next;
            end
            if (in_pop)
                ovalid_reg <= emit;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (in_pop && emit)
            ores_reg <= res;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> (ovalid_reg && $stable(ores_reg)))
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |-> !in_pop)
        else $error("parser stepped while output blocked");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_pop && phase_reg == PH_STOPPED && !in_item.segment_start) |=> !ovalid_reg)
        else $error("result from stopped parser");
endmodule
`default_nettype wire
